// ----- hdl/skf_pkg.sv -----
// Shared constants, state encoding and control structures of the scalar Kalman filter.
package skf_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS       = 12;
    localparam int GAIN_BITS       = 24;
    localparam int GAIN_W          = GAIN_BITS + 1;
    localparam int REG_W           = 32;
    localparam int PROD_W          = REG_W + GAIN_W;
    localparam int DIV_STEPS       = GAIN_BITS;
    localparam int CNT_W           = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W       = 2;

    localparam logic [REG_W-1:0]  Q_RESET   = 32'd150995;
    localparam logic [REG_W-1:0]  R_RESET   = 32'd150995;
    localparam logic [REG_W-1:0]  P0_RESET  = 32'd167772160;
    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << GAIN_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DENOM,
        ST_DIV,
        ST_MULE,
        ST_UPDE,
        ST_MULV,
        ST_UPDV
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic predict;
        logic prep_div;
        logic div_step;
        logic mul_est;
        logic upd_est;
        logic mul_var;
        logic upd_var;
    } t_dp_ctrl;

    typedef struct packed {
        logic skip_div;
    } t_dp_stat;

endpackage

// ----- hdl/skf_ctrl.sv -----
// Sequencer that steps the shared datapath through one filter update.
module skf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_free,
    input  skf_pkg::t_dp_stat   i_stat,
    output skf_pkg::t_dp_ctrl   o_ctrl
);

    skf_pkg::t_state                r_state, n_state;
    logic [skf_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skf_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctrl  = '0;
        unique case (r_state)
            skf_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load_sample = 1'b1;
                    n_state            = skf_pkg::ST_PRED;
                end
            end
            skf_pkg::ST_PRED: begin
                o_ctrl.predict = 1'b1;
                n_state        = skf_pkg::ST_DENOM;
            end
            skf_pkg::ST_DENOM: begin
                // With zero measurement noise the gain is known outright.
                o_ctrl.prep_div = 1'b1;
                n_state = i_stat.skip_div ? skf_pkg::ST_MULE : skf_pkg::ST_DIV;
            end
            skf_pkg::ST_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (r_cnt == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = skf_pkg::ST_MULE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            skf_pkg::ST_MULE: begin
                o_ctrl.mul_est = 1'b1;
                n_state        = skf_pkg::ST_UPDE;
            end
            skf_pkg::ST_UPDE: begin
                o_ctrl.upd_est = 1'b1;
                n_state        = skf_pkg::ST_MULV;
            end
            skf_pkg::ST_MULV: begin
                o_ctrl.mul_var = 1'b1;
                n_state        = skf_pkg::ST_UPDV;
            end
            skf_pkg::ST_UPDV: begin
                // Hold here until the output register can take the word.
                if (i_out_free) begin
                    o_ctrl.upd_var = 1'b1;
                    n_state        = skf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skf_pkg::ST_IDLE;
            end
        endcase
    end

    // No word is taken while reset is held, as it would be lost.
    assign o_in_ready = (r_state == skf_pkg::ST_IDLE) && i_rst_n;

`ifndef SYNTHESIS
    a_cnt_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != skf_pkg::ST_DIV |-> r_cnt == '0)
        else $error("divider step counter left non-zero outside the divide");
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == skf_pkg::ST_PRED)
        else $error("accepted word did not start an update");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_ctrl))
        else $error("more than one datapath operation in a cycle");
    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.upd_var |=> r_state == skf_pkg::ST_IDLE && !o_ctrl.upd_var)
        else $error("update finished without returning to idle");
`endif

endmodule

// ----- hdl/skf_dp.sv -----
// Filter state, configuration registers and the shared divide and multiply datapath.
module skf_dp #(
    parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [skf_pkg::REG_W-1:0]                i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]                   i_sample,
    input  skf_pkg::t_dp_ctrl                        i_ctrl,
    output skf_pkg::t_dp_stat                        o_stat,
    output logic [SAMPLE_BITS+skf_pkg::FRAC_BITS-1:0] o_estimate
);

    localparam int EST_W = SAMPLE_BITS + skf_pkg::FRAC_BITS;
    localparam int REG_W = skf_pkg::REG_W;

    logic [REG_W-1:0]          r_q;
    logic [REG_W-1:0]          r_r;
    logic [REG_W-1:0]          r_var;
    logic [EST_W-1:0]          r_est;

    logic [SAMPLE_BITS-1:0]    r_sample;
    logic [REG_W-1:0]          r_p;
    logic [REG_W:0]            r_den;
    logic [REG_W:0]            r_rem;
    logic [skf_pkg::GAIN_W-1:0] r_gain;
    logic [EST_W-1:0]          r_mag;
    logic                      r_neg;
    logic [skf_pkg::PROD_W-1:0] r_prod;

    logic [REG_W:0]            w_psum;
    logic [EST_W-1:0]          w_target;
    logic [EST_W:0]            w_diff;
    logic [REG_W+1:0]          w_shl;
    logic [REG_W+1:0]          w_sub;
    logic                      w_ge;
    logic [REG_W-1:0]          w_mul_a;
    logic [skf_pkg::PROD_W-1:0] w_prod;
    logic [EST_W-1:0]          w_step;

    assign w_psum   = {1'b0, r_var} + {1'b0, r_q};
    assign w_target = {r_sample, {skf_pkg::FRAC_BITS{1'b0}}};
    assign w_diff   = {1'b0, w_target} - {1'b0, r_est};

    // One restoring divide step: shift the remainder, subtract if it fits.
    assign w_shl = {r_rem, 1'b0};
    assign w_ge  = (w_shl >= {1'b0, r_den});
    assign w_sub = w_shl - {1'b0, r_den};

    // The single multiplier serves both the estimate step and the variance scale.
    assign w_mul_a = i_ctrl.mul_var ? r_p : REG_W'(r_mag);
    assign w_prod  = skf_pkg::PROD_W'(w_mul_a) * skf_pkg::PROD_W'(r_gain);
    assign w_step  = r_prod[skf_pkg::GAIN_BITS +: EST_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= skf_pkg::Q_RESET;
            r_r   <= skf_pkg::R_RESET;
            r_var <= skf_pkg::P0_RESET;
            r_est <= '0;
        end else begin
            if (i_ctrl.upd_est) begin
                r_est <= r_neg ? (r_est - w_step) : (r_est + w_step);
            end
            if (i_ctrl.upd_var) begin
                r_var <= r_prod[skf_pkg::GAIN_BITS +: REG_W];
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    skf_pkg::CFG_PROCESS_NOISE: r_q <= i_cfg_data;
                    skf_pkg::CFG_MEAS_NOISE:    r_r <= i_cfg_data;
                    skf_pkg::CFG_INIT_VAR: begin
                        r_var <= i_cfg_data;
                        r_est <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_sample) begin
            r_sample <= i_sample;
        end
        if (i_ctrl.predict) begin
            r_p <= w_psum[REG_W] ? '1 : w_psum[REG_W-1:0];
        end
        if (i_ctrl.prep_div) begin
            r_den <= {1'b0, r_p} + {1'b0, r_r};
            r_rem <= {1'b0, r_p};
            r_neg <= w_diff[EST_W];
            r_mag <= w_diff[EST_W] ? (r_est - w_target) : w_diff[EST_W-1:0];
            if (o_stat.skip_div) begin
                r_gain <= (r_p == '0) ? '0 : skf_pkg::GAIN_ONE;
            end else begin
                r_gain <= '0;
            end
        end
        if (i_ctrl.div_step) begin
            r_rem  <= w_ge ? w_sub[REG_W:0] : w_shl[REG_W:0];
            r_gain <= {r_gain[skf_pkg::GAIN_W-2:0], w_ge};
        end
        if (i_ctrl.mul_est || i_ctrl.mul_var) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.upd_est) begin
            // The gain register now holds one minus the gain for the variance.
            r_gain <= skf_pkg::GAIN_ONE - r_gain;
        end
    end

    assign o_stat.skip_div = (r_r == '0);
    assign o_estimate      = r_est;

endmodule

// ----- hdl/scalar_kalman_filter_top.sv -----
// Top level of the scalar Kalman filter: stream ports, sequencer, datapath, output register.
//
// Each accepted sample runs one predict-and-correct update of a one-dimensional Kalman
// filter and yields one filtered estimate in unsigned Q12.12. Between accepting a sample
// and loading its estimate into the output register, the restoring divider forms the
// gain one quotient bit per cycle; with zero measurement noise the divide is skipped.
// The input is taken only between updates, but a new sample is accepted while the
// previous estimate still waits in the output register. Configuration writes are
// accepted whenever the block is out of reset and must only be made while the filter
// is idle; writing the initial variance restarts the filter.
module scalar_kalman_filter_top #(
    parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [skf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skf_pkg::REG_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: estimate.
    output logic [((SAMPLE_BITS+skf_pkg::FRAC_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int EST_W      = SAMPLE_BITS + skf_pkg::FRAC_BITS;
    localparam int OUT_DATA_W = ((EST_W + 7) / 8) * 8;

    skf_pkg::t_dp_ctrl  w_ctrl;
    skf_pkg::t_dp_stat  w_stat;
    logic [EST_W-1:0]   w_estimate;
    logic               w_out_free;
    logic               r_out_valid;
    logic [EST_W-1:0]   r_out_data;

    assign o_cfg_ready = i_rst_n;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    skf_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .o_estimate  (w_estimate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.upd_var) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.upd_var) begin
            r_out_data <= w_estimate;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out_data);

endmodule
